// ===== rtl/calendar_date_day_arithmetic_macros.svh =====
// ----------------------------------------------------------------------------
// Calendar date day arithmetic - assertion macros
// Shorthand for the concurrent checks placed at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_DAY_ARITHMETIC_MACROS_SVH
`define CALENDAR_DATE_DAY_ARITHMETIC_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define CDDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define CDDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cdda_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date day arithmetic - package
// Field widths, mode and status codes, and calendar length tables.
// ----------------------------------------------------------------------------
package cdda_pkg;

  localparam int BASE_YEAR     = 2000;
  localparam int YEAR_SPAN_DEF = 256;

  localparam int MODE_W  = 2;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int COUNT_W = 17;
  localparam int DIFF_W  = 18;
  localparam int STAT_W  = 2;

  localparam int DIFF_MAX = 131071;
  localparam int DIFF_MIN = -131072;

  localparam int MONTHS = 12;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET = 2'd0,
    MODE_ADD = 2'd1,
    MODE_SUB = 2'd2,
    MODE_CMP = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_INVALID     = 2'd1,
    ST_CLAMP_START = 2'd2,
    ST_CLAMP_END   = 2'd3
  } status_t;

  // Days in a month; months outside 1..12 never reach this in use.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

endpackage

// ===== rtl/cdda_ifs.sv =====
// ----------------------------------------------------------------------------
// Calendar date day arithmetic - channel interfaces
// Valid/ready channels for the request item and the result item.
// ----------------------------------------------------------------------------
interface cdda_in_if;
  import cdda_pkg::*;

  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [DAY_W-1:0]   new_day;
  logic [MONTH_W-1:0] new_month;
  logic [YEAR_W-1:0]  new_year;
  logic [COUNT_W-1:0] day_count;

  modport source (output valid, mode, new_day, new_month, new_year, day_count,
                  input ready);
  modport sink   (input valid, mode, new_day, new_month, new_year, day_count,
                  output ready);
endinterface

interface cdda_out_if;
  import cdda_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [DAY_W-1:0]         out_day;
  logic [MONTH_W-1:0]       out_month;
  logic [YEAR_W-1:0]        out_year;
  logic                     leap_flag;
  logic signed [DIFF_W-1:0] difference;
  logic                     is_equal;
  logic                     is_less;
  logic                     is_greater;
  logic [STAT_W-1:0]        status;

  modport source (output valid, out_day, out_month, out_year, leap_flag, difference,
                  is_equal, is_less, is_greater, status,
                  input ready);
  modport sink   (input valid, out_day, out_month, out_year, leap_flag, difference,
                  is_equal, is_less, is_greater, status,
                  output ready);
endinterface

// ===== rtl/calendar_date_day_arithmetic.sv =====
// Throughput: one item at a time; the year walk (one year per cycle) and the
//   month walk (one month per cycle) through a single adder set the figure.
// A finished result sits in the output register, so the next item is taken
//   while the previous result still waits.
// Reset (rst_n low, synchronous): current date 2000-01-01, no result pending.
// ----------------------------------------------------------------------------
// Calendar date day arithmetic - top level
// Keeps a current Gregorian date and a running day number since 2000-01-01.
// Set, add, subtract and compare run through one shared add/compare unit
// that walks years, then months, under a small sequencer.
// ----------------------------------------------------------------------------
`include "calendar_date_day_arithmetic_macros.svh"

module calendar_date_day_arithmetic #(
  parameter int YEAR_SPAN = cdda_pkg::YEAR_SPAN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cdda_in_if.sink    in_ch,
  cdda_out_if.source out_ch
);
  import cdda_pkg::*;

  // Year offset width, last valid day number and day-number width.
  localparam int OFFW      = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN) : 1;
  localparam int END_YEAR  = BASE_YEAR + YEAR_SPAN - 1;
  localparam int LEAPS     = (END_YEAR / 4 - (BASE_YEAR - 1) / 4)
                           - (END_YEAR / 100 - (BASE_YEAR - 1) / 100)
                           + (END_YEAR / 400 - (BASE_YEAR - 1) / 400);
  localparam int LAST_DAY  = 365 * YEAR_SPAN + LEAPS - 1;
  localparam int DAYW      = $clog2(LAST_DAY + (1 << COUNT_W) + 1);
  localparam int DW        = DAYW + 1;
  localparam int LAST_OFF  = YEAR_SPAN - 1;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_TY, S_TM, S_TFIN, S_CMPD, S_FY, S_FM, S_DONE
  } state_t;

  // Sequencer and current date.
  state_t              state_r, state_nxt;
  logic [DAY_W-1:0]    cur_day_r, cur_day_nxt;
  logic [MONTH_W-1:0]  cur_mon_r, cur_mon_nxt;
  logic [OFFW-1:0]     cur_off_r, cur_off_nxt;
  logic                cur_leap_r, cur_leap_nxt;
  logic [DAYW-1:0]     cur_days_r, cur_days_nxt;

  // Latched request.
  mode_t               mode_r, mode_nxt;
  logic [DAY_W-1:0]    nd_r, nd_nxt;
  logic [MONTH_W-1:0]  nm_r, nm_nxt;
  logic [OFFW-1:0]     tgt_off_r, tgt_off_nxt;
  logic                yr_ok_r, yr_ok_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;

  // Walk registers: year offset with its remainders, month, day accumulator.
  logic [OFFW-1:0]     off_r, off_nxt;
  logic [1:0]          mod4_r, mod4_nxt;
  logic [6:0]          mod100_r, mod100_nxt;
  logic [8:0]          mod400_r, mod400_nxt;
  logic [MONTH_W-1:0]  mon_r, mon_nxt;
  logic [DAYW-1:0]     acc_r, acc_nxt;
  logic [DAYW-1:0]     g_r, g_nxt;

  // Result under construction.
  logic signed [DW-1:0] diff_r, diff_nxt;
  logic                 eq_r, eq_nxt, lt_r, lt_nxt, gt_r, gt_nxt;
  status_t              stat_r, stat_nxt;

  // Output register.
  logic                     ov_r, ov_nxt;
  logic [DAY_W-1:0]         o_day_r, o_day_nxt;
  logic [MONTH_W-1:0]       o_mon_r, o_mon_nxt;
  logic [YEAR_W-1:0]        o_year_r, o_year_nxt;
  logic                     o_leap_r, o_leap_nxt;
  logic signed [DIFF_W-1:0] o_diff_r, o_diff_nxt;
  logic                     o_eq_r, o_eq_nxt, o_lt_r, o_lt_nxt, o_gt_r, o_gt_nxt;
  logic [STAT_W-1:0]        o_stat_r, o_stat_nxt;

  // Shared datapath terms.
  logic                 leap_w;
  logic [8:0]           ylen_w;
  logic [DAY_W-1:0]     mlen_w;
  logic [DAY_W-1:0]     mlen_given_w;
  logic [DW-1:0]        sub_y_w;
  logic [DW-1:0]        sub_m_w;
  logic [DAYW-1:0]      sum_add_w;
  logic [12:0]          yr_rel_w;
  logic [12:0]          yr_full_w;
  logic                 in_acc_w;
  logic                 out_free_w;
  logic signed [DIFF_W-1:0] diff_sat_w;

  // Terms watched by the checks.
  logic                 cur_date_ok_w;
  logic                 days_ok_w;
  logic                 done_go_w;

  assign in_acc_w   = in_ch.valid && in_ch.ready;
  assign out_free_w = !ov_r || out_ch.ready;

  // Leap rule on the walked year, tracked by running remainders.
  assign leap_w       = (mod4_r == 2'd0) && ((mod100_r != 7'd0) || (mod400_r == 9'd0));
  assign ylen_w       = year_len(leap_w);
  assign mlen_w       = month_len(mon_r, leap_w);
  assign mlen_given_w = month_len(nm_r, leap_w);
  assign sub_y_w      = {1'b0, acc_r} - DW'(ylen_w);
  assign sub_m_w      = {1'b0, acc_r} - DW'(mlen_w);
  assign sum_add_w    = cur_days_r + DAYW'(cnt_r);
  assign yr_rel_w     = 13'(in_ch.new_year) - 13'(BASE_YEAR);
  assign yr_full_w    = 13'(BASE_YEAR) + 13'(cur_off_r);

  // Clip the wide difference into the 18-bit result field.
  always_comb begin
    if (diff_r > $signed(DW'(DIFF_MAX))) begin
      diff_sat_w = 18'sh1FFFF;
    end else if (diff_r < $signed(DW'(DIFF_MIN))) begin
      diff_sat_w = 18'sh20000;
    end else begin
      diff_sat_w = diff_r[DIFF_W-1:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cur_day_nxt  = cur_day_r;
    cur_mon_nxt  = cur_mon_r;
    cur_off_nxt  = cur_off_r;
    cur_leap_nxt = cur_leap_r;
    cur_days_nxt = cur_days_r;
    mode_nxt     = mode_r;
    nd_nxt       = nd_r;
    nm_nxt       = nm_r;
    tgt_off_nxt  = tgt_off_r;
    yr_ok_nxt    = yr_ok_r;
    cnt_nxt      = cnt_r;
    off_nxt      = off_r;
    mod4_nxt     = mod4_r;
    mod100_nxt   = mod100_r;
    mod400_nxt   = mod400_r;
    mon_nxt      = mon_r;
    acc_nxt      = acc_r;
    g_nxt        = g_r;
    diff_nxt     = diff_r;
    eq_nxt       = eq_r;
    lt_nxt       = lt_r;
    gt_nxt       = gt_r;
    stat_nxt     = stat_r;
    ov_nxt       = ov_r && !out_ch.ready;
    o_day_nxt    = o_day_r;
    o_mon_nxt    = o_mon_r;
    o_year_nxt   = o_year_r;
    o_leap_nxt   = o_leap_r;
    o_diff_nxt   = o_diff_r;
    o_eq_nxt     = o_eq_r;
    o_lt_nxt     = o_lt_r;
    o_gt_nxt     = o_gt_r;
    o_stat_nxt   = o_stat_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc_w) begin
          // Latch the item and rewind the walk to 2000-01.
          mode_nxt    = mode_t'(in_ch.mode);
          nd_nxt      = in_ch.new_day;
          nm_nxt      = in_ch.new_month;
          cnt_nxt     = in_ch.day_count;
          yr_ok_nxt   = (in_ch.new_year >= YEAR_W'(BASE_YEAR))
                        && (yr_rel_w < 13'(YEAR_SPAN));
          tgt_off_nxt = yr_rel_w[OFFW-1:0];
          off_nxt     = '0;
          mod4_nxt    = '0;
          mod100_nxt  = '0;
          mod400_nxt  = '0;
          mon_nxt     = MONTH_W'(1);
          acc_nxt     = '0;
          diff_nxt    = '0;
          eq_nxt      = 1'b0;
          lt_nxt      = 1'b0;
          gt_nxt      = 1'b0;
          stat_nxt    = ST_OK;
          state_nxt   = S_PREP;
        end
      end

      S_PREP: begin
        case (mode_r)
          MODE_SET, MODE_CMP: begin
            if (yr_ok_r && (nm_r != '0) && (nm_r <= MONTH_W'(MONTHS)) && (nd_r != '0)) begin
              state_nxt = S_TY;
            end else if (mode_r == MODE_SET) begin
              cur_day_nxt  = DAY_W'(1);
              cur_mon_nxt  = MONTH_W'(1);
              cur_off_nxt  = '0;
              cur_leap_nxt = 1'b1;
              cur_days_nxt = '0;
              stat_nxt     = ST_INVALID;
              state_nxt    = S_DONE;
            end else begin
              g_nxt     = '0;
              stat_nxt  = ST_INVALID;
              state_nxt = S_CMPD;
            end
          end
          MODE_ADD: begin
            if (sum_add_w > DAYW'(LAST_DAY)) begin
              acc_nxt  = DAYW'(LAST_DAY);
              stat_nxt = ST_CLAMP_END;
            end else begin
              acc_nxt = sum_add_w;
            end
            state_nxt = S_FY;
          end
          default: begin
            if (DAYW'(cnt_r) > cur_days_r) begin
              acc_nxt  = '0;
              stat_nxt = ST_CLAMP_START;
            end else begin
              acc_nxt = cur_days_r - DAYW'(cnt_r);
            end
            state_nxt = S_FY;
          end
        endcase
      end

      // Date to day number: add whole years up to the target year.
      S_TY: begin
        if (off_r == tgt_off_r) begin
          state_nxt = S_TM;
        end else begin
          acc_nxt    = acc_r + DAYW'(ylen_w);
          off_nxt    = off_r + 1'b1;
          mod4_nxt   = mod4_r + 1'b1;
          mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 1'b1;
          mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 1'b1;
        end
      end

      // Then whole months up to the target month.
      S_TM: begin
        if (mon_r == nm_r) begin
          state_nxt = S_TFIN;
        end else begin
          acc_nxt = acc_r + DAYW'(mlen_w);
          mon_nxt = mon_r + 1'b1;
        end
      end

      // Check the day against the month length now that leap is known.
      S_TFIN: begin
        if (nd_r > mlen_given_w) begin
          stat_nxt = ST_INVALID;
          if (mode_r == MODE_SET) begin
            cur_day_nxt  = DAY_W'(1);
            cur_mon_nxt  = MONTH_W'(1);
            cur_off_nxt  = '0;
            cur_leap_nxt = 1'b1;
            cur_days_nxt = '0;
            state_nxt    = S_DONE;
          end else begin
            g_nxt     = '0;
            state_nxt = S_CMPD;
          end
        end else begin
          g_nxt = acc_r + DAYW'(nd_r) - DAYW'(1);
          if (mode_r == MODE_SET) begin
            cur_day_nxt  = nd_r;
            cur_mon_nxt  = nm_r;
            cur_off_nxt  = tgt_off_r;
            cur_leap_nxt = leap_w;
            cur_days_nxt = acc_r + DAYW'(nd_r) - DAYW'(1);
            state_nxt    = S_DONE;
          end else begin
            state_nxt = S_CMPD;
          end
        end
      end

      S_CMPD: begin
        diff_nxt  = $signed({1'b0, cur_days_r}) - $signed({1'b0, g_r});
        eq_nxt    = (cur_days_r == g_r);
        lt_nxt    = (cur_days_r < g_r);
        gt_nxt    = (cur_days_r > g_r);
        state_nxt = S_DONE;
      end

      // Day number to date: peel whole years while they fit.
      S_FY: begin
        if ((13'(off_r) < 13'(LAST_OFF)) && !sub_y_w[DAYW]) begin
          acc_nxt    = sub_y_w[DAYW-1:0];
          off_nxt    = off_r + 1'b1;
          mod4_nxt   = mod4_r + 1'b1;
          mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 1'b1;
          mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 1'b1;
        end else begin
          cur_days_nxt = (mode_r == MODE_ADD) ? sum_add_w : cur_days_r - DAYW'(cnt_r);
          if (stat_r == ST_CLAMP_END) begin
            cur_days_nxt = DAYW'(LAST_DAY);
          end else if (stat_r == ST_CLAMP_START) begin
            cur_days_nxt = '0;
          end
          state_nxt = S_FM;
        end
      end

      // Then whole months; the remainder is the day.
      S_FM: begin
        if ((mon_r < MONTH_W'(MONTHS)) && !sub_m_w[DAYW]) begin
          acc_nxt = sub_m_w[DAYW-1:0];
          mon_nxt = mon_r + 1'b1;
        end else begin
          cur_day_nxt  = acc_r[DAY_W-1:0] + 1'b1;
          cur_mon_nxt  = mon_r;
          cur_off_nxt  = off_r;
          cur_leap_nxt = leap_w;
          state_nxt    = S_DONE;
        end
      end

      // Hold here until the output register is free.
      S_DONE: begin
        if (out_free_w) begin
          ov_nxt     = 1'b1;
          o_day_nxt  = cur_day_r;
          o_mon_nxt  = cur_mon_r;
          o_year_nxt = yr_full_w[YEAR_W-1:0];
          o_leap_nxt = cur_leap_r;
          o_diff_nxt = diff_sat_w;
          o_eq_nxt   = eq_r;
          o_lt_nxt   = lt_r;
          o_gt_nxt   = gt_r;
          o_stat_nxt = stat_r;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cur_day_r  <= DAY_W'(1);
      cur_mon_r  <= MONTH_W'(1);
      cur_off_r  <= '0;
      cur_leap_r <= 1'b1;
      cur_days_r <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cur_day_r  <= cur_day_nxt;
      cur_mon_r  <= cur_mon_nxt;
      cur_off_r  <= cur_off_nxt;
      cur_leap_r <= cur_leap_nxt;
      cur_days_r <= cur_days_nxt;
      ov_r       <= ov_nxt;
    end
    mode_r    <= mode_nxt;
    nd_r      <= nd_nxt;
    nm_r      <= nm_nxt;
    tgt_off_r <= tgt_off_nxt;
    yr_ok_r   <= yr_ok_nxt;
    cnt_r     <= cnt_nxt;
    off_r     <= off_nxt;
    mod4_r    <= mod4_nxt;
    mod100_r  <= mod100_nxt;
    mod400_r  <= mod400_nxt;
    mon_r     <= mon_nxt;
    acc_r     <= acc_nxt;
    g_r       <= g_nxt;
    diff_r    <= diff_nxt;
    eq_r      <= eq_nxt;
    lt_r      <= lt_nxt;
    gt_r      <= gt_nxt;
    stat_r    <= stat_nxt;
    o_day_r   <= o_day_nxt;
    o_mon_r   <= o_mon_nxt;
    o_year_r  <= o_year_nxt;
    o_leap_r  <= o_leap_nxt;
    o_diff_r  <= o_diff_nxt;
    o_eq_r    <= o_eq_nxt;
    o_lt_r    <= o_lt_nxt;
    o_gt_r    <= o_gt_nxt;
    o_stat_r  <= o_stat_nxt;
  end

  // Channel ports.
  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = ov_r;
  assign out_ch.out_day    = o_day_r;
  assign out_ch.out_month  = o_mon_r;
  assign out_ch.out_year   = o_year_r;
  assign out_ch.leap_flag  = o_leap_r;
  assign out_ch.difference = o_diff_r;
  assign out_ch.is_equal   = o_eq_r;
  assign out_ch.is_less    = o_lt_r;
  assign out_ch.is_greater = o_gt_r;
  assign out_ch.status     = o_stat_r;

  // Checks: the held date is always a real calendar date, its day number is
  // inside the span while idle, and a finished item always lands in the output register.
  assign cur_date_ok_w = (cur_mon_r != '0) && (cur_mon_r <= MONTH_W'(MONTHS))
                         && (cur_day_r != '0)
                         && (cur_day_r <= month_len(cur_mon_r, cur_leap_r));
  assign days_ok_w     = (cur_days_r <= DAYW'(LAST_DAY));
  assign done_go_w     = (state_r == S_DONE) && out_free_w;

  `CDDA_ASSERT_IMP(a_cur_date_real, 1'b1, cur_date_ok_w, "current date is not a calendar date")
  `CDDA_ASSERT_IMP(a_day_number_span, state_r == S_IDLE, days_ok_w, "day number beyond span")
  `CDDA_ASSERT_NXT(a_result_loaded, done_go_w, ov_r && (state_r == S_IDLE), "result not loaded")

endmodule
